### sv/wfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_pkg: shared constants, tables and types of the windowed FFT magnitude
// Holds the frame geometry, the Hamming window and twiddle ROMs (built at
// elaboration), the state types and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package wfm_pkg;

  // Frame geometry.
  localparam int FFT_SIZE  = 256;
  localparam int ADDR_W    = $clog2(FFT_SIZE);
  localparam int HALF      = (FFT_SIZE / 2 + 1) / 2;
  localparam int NRES      = FFT_SIZE / 4;
  localparam int NBINS     = NRES - 1;
  localparam int FIRST_BIN = HALF + 1;
  localparam int J_W       = $clog2(NRES);
  localparam int WIN_DIV   = FFT_SIZE - 1;

  // Data widths.
  localparam int SAMPLE_W = 32;
  localparam int WIN_W    = 18;
  localparam int TW_W     = 32;
  localparam int ACC_W    = SAMPLE_W + ADDR_W + 1;
  localparam int ABS_W    = ACC_W - 1;
  localparam int ROOT_W   = ABS_W + 1;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int MAG_W    = 40;
  localparam int SAT_W    = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;
  localparam int MCNT_W   = $clog2(ROOT_W + 1);

  // Fixed-point constants of the trig generator and window.
  localparam longint Q30_ONE  = 64'sd1073741824;
  localparam longint PI4_Q30  = 64'sd843314857;
  localparam longint C054_Q30 = 64'sd579820585;
  localparam longint C046_Q30 = 64'sd493921239;

  typedef logic signed [TW_W-1:0] tw_tab_t [FFT_SIZE];
  typedef logic [WIN_W-1:0] win_tab_t [FFT_SIZE];

  typedef struct packed {
    logic signed [63:0] s;
    logic signed [63:0] c;
  } sc_t;

  // Round to nearest, ties away from zero, by an arithmetic right shift.
  function automatic longint round_shift(input longint v, input int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    return (v + half - ((v < 0) ? longint'(1) : longint'(0))) >>> sh;
  endfunction

  // Sine and cosine in Q30 of a phase given as a 32-bit fraction of a turn.
  function automatic sc_t sin_cos(input longint th);
    longint oct, r, x, x2, ts, tc, ss, cc, sa, ca;
    sc_t res;
    oct = (th >>> 29) & 7;
    r = th & 64'h1FFFFFFF;
    if (oct[0]) r = 64'sh20000000 - r;
    x  = (r * PI4_Q30) >>> 29;
    x2 = (x * x) >>> 30;
    ts = Q30_ONE - ((x2 * Q30_ONE) >>> 30) / 156;
    ts = Q30_ONE - ((x2 * ts) >>> 30) / 110;
    ts = Q30_ONE - ((x2 * ts) >>> 30) / 72;
    ts = Q30_ONE - ((x2 * ts) >>> 30) / 42;
    ts = Q30_ONE - ((x2 * ts) >>> 30) / 20;
    ts = Q30_ONE - ((x2 * ts) >>> 30) / 6;
    ss = (x * ts) >>> 30;
    tc = Q30_ONE - ((x2 * Q30_ONE) >>> 30) / 132;
    tc = Q30_ONE - ((x2 * tc) >>> 30) / 90;
    tc = Q30_ONE - ((x2 * tc) >>> 30) / 56;
    tc = Q30_ONE - ((x2 * tc) >>> 30) / 30;
    tc = Q30_ONE - ((x2 * tc) >>> 30) / 12;
    cc = Q30_ONE - ((x2 * tc) >>> 30) / 2;
    if (oct[0]) begin
      sa = cc;
      ca = ss;
    end else begin
      sa = ss;
      ca = cc;
    end
    case (oct >>> 1)
      0: begin res.s = sa;  res.c = ca;  end
      1: begin res.s = ca;  res.c = -sa; end
      2: begin res.s = -sa; res.c = -ca; end
      default: begin res.s = -ca; res.c = sa; end
    endcase
    return res;
  endfunction

  function automatic tw_tab_t gen_tw_cos();
    tw_tab_t t;
    sc_t sc;
    for (int i = 0; i < FFT_SIZE; i++) begin
      sc = sin_cos(((longint'(i) <<< 32) / FFT_SIZE) & 64'hFFFFFFFF);
      t[i] = sc.c[TW_W-1:0];
    end
    return t;
  endfunction

  function automatic tw_tab_t gen_tw_sin();
    tw_tab_t t;
    sc_t sc;
    for (int i = 0; i < FFT_SIZE; i++) begin
      sc = sin_cos(((longint'(i) <<< 32) / FFT_SIZE) & 64'hFFFFFFFF);
      t[i] = sc.s[TW_W-1:0];
    end
    return t;
  endfunction

  function automatic win_tab_t gen_window();
    win_tab_t t;
    sc_t sc;
    longint h30, w;
    for (int i = 0; i < FFT_SIZE; i++) begin
      sc = sin_cos(((longint'(i) <<< 32) / WIN_DIV) & 64'hFFFFFFFF);
      h30 = C054_Q30 - round_shift(C046_Q30 * sc.c, 30);
      w = round_shift(h30, 13);
      t[i] = w[WIN_W-1:0];
    end
    return t;
  endfunction

  localparam tw_tab_t  TW_COS  = gen_tw_cos();
  localparam tw_tab_t  TW_SIN  = gen_tw_sin();
  localparam win_tab_t WIN_ROM = gen_window();

  localparam logic [SAT_W-1:0] MAG_MAX = SAT_W'({MAG_W{1'b1}});

  // Controller states.
  typedef enum logic [2:0] {
    S_LOAD, S_START, S_MAC, S_DRAIN, S_MAG, S_WAIT, S_EMIT, S_EMIT_LAST
  } wfm_state_t;

  // Magnitude unit phases.
  typedef enum logic [1:0] {
    MAG_IDLE, MAG_SQUARE, MAG_ROOT
  } mag_phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic [ADDR_W-1:0] addr;
    logic              acc_clear;
    logic              issue;
    logic [ADDR_W-1:0] bin;
    logic              mag_start;
    logic              out_mag;
    logic              out_zero;
  } wfm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_empty;
    logic mag_done;
  } wfm_stat_t;

endpackage

### sv/wfm_mag.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_mag: serial magnitude unit
// Forms re^2 + im^2 by shift-and-add, one bit per cycle, then takes the
// floor square root one result bit per cycle and saturates it.
// ----------------------------------------------------------------------------
module wfm_mag (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [wfm_pkg::ACC_W-1:0] re,
  input  logic signed [wfm_pkg::ACC_W-1:0] im,
  output logic                             done,
  output logic [wfm_pkg::MAG_W-1:0]        mag
);
  import wfm_pkg::*;

  mag_phase_t        phase;
  logic [MCNT_W-1:0] cnt;
  logic [ABS_W-1:0]  a_bits, b_bits;
  logic [RAD_W-1:0]  a_sh, b_sh, sq;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;

  logic [ACC_W-1:0]  re_abs, im_abs;
  logic [REM_W-1:0]  rem2, trial;
  logic [SAT_W-1:0]  root_wide;

  assign re_abs = re[ACC_W-1] ? ACC_W'(-re) : ACC_W'(re);
  assign im_abs = im[ACC_W-1] ? ACC_W'(-im) : ACC_W'(im);

  // One restoring square-root step.
  assign rem2  = {rem[REM_W-3:0], sq[RAD_W-1 -: 2]};
  assign trial = REM_W'({root, 2'b01});

  // Sequencing of the square and root phases.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MAG_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        MAG_IDLE: begin
          if (start) begin
            phase <= MAG_SQUARE;
            cnt   <= '0;
          end
        end
        MAG_SQUARE: begin
          if (cnt == MCNT_W'(ABS_W - 1)) begin
            phase <= MAG_ROOT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        MAG_ROOT: begin
          if (cnt == MCNT_W'(ROOT_W - 1)) begin
            phase <= MAG_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: phase <= MAG_IDLE;
      endcase
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    case (phase)
      MAG_IDLE: begin
        if (start) begin
          a_bits <= re_abs[ABS_W-1:0];
          b_bits <= im_abs[ABS_W-1:0];
          a_sh   <= RAD_W'(re_abs[ABS_W-1:0]);
          b_sh   <= RAD_W'(im_abs[ABS_W-1:0]);
          sq     <= '0;
        end
      end
      MAG_SQUARE: begin
        sq <= sq + (a_bits[0] ? a_sh : '0) + (b_bits[0] ? b_sh : '0);
        a_bits <= a_bits >> 1;
        b_bits <= b_bits >> 1;
        a_sh   <= a_sh << 1;
        b_sh   <= b_sh << 1;
        rem    <= '0;
        root   <= '0;
      end
      MAG_ROOT: begin
        sq <= sq << 2;
        if (rem2 >= trial) begin
          rem  <= rem2 - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem2;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Saturate to the output width.
  assign root_wide = SAT_W'(root);
  assign mag = (root_wide > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : root_wide[MAG_W-1:0];

endmodule

### sv/wfm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_dp: datapath of the windowed FFT magnitude
// Windows and stores the samples, runs the pipelined complex MAC over the
// frame for one bin, and holds the output result register.
// ----------------------------------------------------------------------------
module wfm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  wfm_pkg::wfm_cmd_t                   cmd,
  output wfm_pkg::wfm_stat_t                  stat,
  input  logic signed [wfm_pkg::SAMPLE_W-1:0] sample,
  output logic [wfm_pkg::MAG_W-1:0]           magnitude
);
  import wfm_pkg::*;

  logic signed [SAMPLE_W-1:0] smem [FFT_SIZE];

  logic [ADDR_W-1:0]          phase;
  logic                       v1, v2;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [TW_W-1:0]     cos_q, sin_q;
  logic signed [63:0]         pc, ps;
  logic signed [ACC_W-1:0]    acc_re, acc_im;
  logic [MAG_W-1:0]           mag_q;

  logic signed [50:0]         wprod;
  logic signed [50:0]         wround;
  logic signed [63:0]         rc, rs;
  logic [MAG_W-1:0]           mag_root;
  logic                       mag_done;

  // Windowing: sample times Hamming weight, rounded back to Q.31.
  assign wprod  = 51'(sample) * 51'(signed'({1'b0, WIN_ROM[cmd.addr]}));
  assign wround = (wprod + 51'sd65536 - (wprod < 0 ? 51'sd1 : 51'sd0)) >>> 17;

  // Sample store: one write port for loading, one registered read for the MAC.
  always_ff @(posedge clk) begin
    if (cmd.load) smem[cmd.addr] <= wround[SAMPLE_W-1:0];
    if (cmd.issue) x_q <= smem[cmd.addr];
  end

  // Twiddle lookup and phase step (phase = index * bin mod N).
  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      phase <= '0;
    end else if (cmd.issue) begin
      cos_q <= TW_COS[phase];
      sin_q <= TW_SIN[phase];
      phase <= phase + cmd.bin;
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    pc <= 64'(x_q) * 64'(cos_q);
    ps <= 64'(x_q) * 64'(sin_q);
  end

  // Each product is rounded to Q.31 before it is summed.
  assign rc = (pc + 64'sd536870912 - (pc < 0 ? 64'sd1 : 64'sd0)) >>> 30;
  assign rs = (ps + 64'sd536870912 - (ps < 0 ? 64'sd1 : 64'sd0)) >>> 30;

  // Pipeline valid flags and the accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      acc_re <= acc_re + rc[ACC_W-1:0];
      acc_im <= acc_im - rs[ACC_W-1:0];
    end
  end

  // Status back to the controller.
  assign stat.pipe_empty = !v1 && !v2;
  assign stat.mag_done   = mag_done;

  wfm_mag u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mag_start),
    .re    (acc_re),
    .im    (acc_im),
    .done  (mag_done),
    .mag   (mag_root)
  );

  // Output result register.
  always_ff @(posedge clk) begin
    if (cmd.out_mag) mag_q <= mag_root;
    else if (cmd.out_zero) mag_q <= '0;
  end

  assign magnitude = mag_q;

endmodule

### sv/wfm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfm_ctrl: frame sequencer
// Loads the frame, then for each bin runs the MAC sweep, the magnitude unit
// and the output transfer, and closes the frame with a zero result.
// ----------------------------------------------------------------------------
module wfm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic                m_tlast,
  output wfm_pkg::wfm_cmd_t   cmd,
  input  wfm_pkg::wfm_stat_t  stat
);
  import wfm_pkg::*;

  wfm_state_t        state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [J_W-1:0]    jbin, jbin_next;

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      idx   <= '0;
      jbin  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      jbin  <= jbin_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    jbin_next     = jbin;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    m_tlast       = 1'b0;
    cmd           = '0;
    cmd.addr      = idx;
    cmd.bin       = ADDR_W'(FIRST_BIN) + ADDR_W'(jbin);
    case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          idx_next = idx + 1'b1;
          if (idx == ADDR_W'(FFT_SIZE - 1)) state_next = S_START;
        end
      end
      S_START: begin
        cmd.acc_clear = 1'b1;
        idx_next      = '0;
        state_next    = S_MAC;
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        idx_next  = idx + 1'b1;
        if (idx == ADDR_W'(FFT_SIZE - 1)) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (stat.pipe_empty) state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (stat.mag_done) begin
          cmd.out_mag = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (jbin == J_W'(NBINS - 1)) begin
            cmd.out_zero = 1'b1;
            jbin_next    = '0;
            state_next   = S_EMIT_LAST;
          end else begin
            jbin_next  = jbin + 1'b1;
            state_next = S_START;
          end
        end
      end
      S_EMIT_LAST: begin
        m_tvalid = 1'b1;
        m_tlast  = 1'b1;
        if (m_tready) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_mag_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.mag_start |-> stat.pipe_empty)
    else $error("magnitude started with products still in flight");

  a_last_follows_bin: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_LAST && $past(state) != S_EMIT_LAST) |-> $past(state) == S_EMIT)
    else $error("final zero result not preceded by a bin result");

  a_no_load_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !cmd.load && !s_tready)
    else $error("sample load during MAC sweep");

  a_load_done_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && idx == ADDR_W'(FFT_SIZE - 1)) |=> state == S_START)
    else $error("full frame did not start the transform");
`endif

endmodule

### sv/windowed_fft_magnitude_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_fft_magnitude_frame: Hamming-windowed DFT magnitude of a frame
// Collects FFT_SIZE samples, windows them, and emits FFT_SIZE/4 bin
// magnitudes of the upper-middle bins, the last one being zero.
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata low bit up)          notes
//  s_axis   in   tdata[31:0] = sample (signed Q1.31) one sample per transfer
//  m_axis   out  tdata[39:0] = magnitude; tlast      tlast on the frame's last
//
// Loading accepts samples back to back. Each bin then runs these steps in
// order: clear the accumulators, issue the MAC once per sample, drain the
// MAC pipeline, start the magnitude unit, wait while it squares and roots,
// and present the result. The closing zero result follows the last bin.
// Reset is synchronous and clears the sequencer; samples are not accepted
// while bins are computed, and a stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module windowed_fft_magnitude_frame (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [39:0] magnitude
  output logic        m_tlast
);
  import wfm_pkg::*;

  wfm_cmd_t  cmd;
  wfm_stat_t stat;

  wfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

  wfm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample    (signed'(s_tdata)),
    .magnitude (m_tdata)
  );

endmodule
